// ===== design/sws_pkg.sv =====
// Shared constants, register codes and widths for the square window sum block.
// No dependencies; used by the interfaces, the RAM users and the top level.
`default_nettype none

package sws_pkg;

    localparam int MAX_WIN    = 16;
    localparam int MAX_SIZE   = 1024;

    localparam int WIN_IDX_W  = $clog2(MAX_WIN);
    localparam int WIN_W      = $clog2(MAX_WIN + 1);
    localparam int POS_W      = $clog2(MAX_SIZE);
    localparam int SIZE_W     = $clog2(MAX_SIZE + 1);

    localparam int SAMPLE_W   = 16;
    localparam int HSUM_W     = 21;
    localparam int CSUM_W     = 25;
    localparam int WSUM_W     = 24;

    localparam int HDEPTH     = MAX_WIN * MAX_SIZE;
    localparam int HADDR_W    = WIN_IDX_W + POS_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int WIN_CFG_W  = 5;
    localparam int SIZE_CFG_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE  = CFG_IDX_W'(1);

endpackage

`default_nettype wire

// ===== design/sws_pixel_if.sv =====
// Input channel of the square window sum block: one signed sample per transfer.
// Depends on sws_pkg.
`default_nettype none

interface sws_pixel_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sws_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== design/sws_sum_if.sv =====
// Output channel of the square window sum block: one window sum and its position per transfer.
// Depends on sws_pkg.
`default_nettype none

interface sws_sum_if;
    logic                                valid;
    logic                                ready;
    logic signed [sws_pkg::WSUM_W-1:0]   window_sum;
    logic        [sws_pkg::POS_W-1:0]    out_row;
    logic        [sws_pkg::POS_W-1:0]    out_col;
    logic                                last_window;

    modport source (output valid, output window_sum, output out_row, output out_col,
                    output last_window, input ready);
    modport sink   (input valid, input window_sum, input out_row, input out_col,
                    input last_window, output ready);
endinterface

`default_nettype wire

// ===== design/sws_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module sws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [$clog2(DEPTH)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]          wdata,
    input  wire logic                      re,
    input  wire logic [$clog2(DEPTH)-1:0]  raddr,
    output logic      [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/square_window_sum.sv =====
// Square window sum: m by m box sums over an n by n raster image of signed samples.
// Pipeline: a result is registered in s1, then s2, then s3, where it is valid; output stalls can hold it.
// Throughput: one sample per cycle while the output is not stalled, set by the three-stage
// pipeline and the one-read/one-write line and column memories.
// Reset: counters cleared, window size 1, image size 1024; memories are not cleared.
// Depends on sws_pkg, sws_pixel_if, sws_sum_if, sws_ram.
`default_nettype none

module square_window_sum (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [sws_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sws_pkg::CFG_DATA_W-1:0]    cfg_data,
    sws_pixel_if.sink                              pixels,
    sws_sum_if.source                              sums
);

    typedef struct packed {
        logic [sws_pkg::SAMPLE_W-1:0]   sample;
        logic [sws_pkg::POS_W-1:0]      col;
        logic                           first_col;
        logic                           sub_col;
        logic                           has_hsum;
        logic                           first_row;
        logic                           sub_row;
        logic                           emit;
        logic                           last;
        logic [sws_pkg::WIN_IDX_W-1:0]  rw_old;
        logic [sws_pkg::HADDR_W-1:0]    slot_old;
        logic [sws_pkg::HADDR_W-1:0]    slot_new;
        logic [sws_pkg::POS_W-1:0]      out_row;
        logic [sws_pkg::POS_W-1:0]      out_col;
    } s1_t;

    typedef struct packed {
        logic [sws_pkg::HSUM_W-1:0]     hsum;
        logic [sws_pkg::POS_W-1:0]      col;
        logic                           first_row;
        logic                           sub_row;
        logic                           has_hsum;
        logic                           emit;
        logic                           last;
        logic [sws_pkg::HADDR_W-1:0]    slot_new;
        logic [sws_pkg::POS_W-1:0]      out_row;
        logic [sws_pkg::POS_W-1:0]      out_col;
    } s2_t;

    typedef struct packed {
        logic [sws_pkg::WSUM_W-1:0]     wsum;
        logic [sws_pkg::POS_W-1:0]      out_row;
        logic [sws_pkg::POS_W-1:0]      out_col;
        logic                           last;
    } s3_t;

    logic [sws_pkg::WIN_W-1:0]   win_reg,  win_next;
    logic [sws_pkg::SIZE_W-1:0]  size_reg, size_next;
    logic [sws_pkg::POS_W-1:0]   row_reg,  row_next;
    logic [sws_pkg::POS_W-1:0]   col_reg,  col_next;
    logic                        v1_reg, v1_next;
    logic                        v2_reg, v2_next;
    logic                        v3_reg, v3_next;
    s1_t                         s1_reg, s1_next;
    s2_t                         s2_reg, s2_next;
    s3_t                         s3_reg, s3_next;
    logic signed [sws_pkg::HSUM_W-1:0]   run_reg, run_next;
    logic [sws_pkg::SAMPLE_W-1:0]        row_window_reg [sws_pkg::MAX_WIN];

    logic [sws_pkg::WIN_CFG_W-1:0]   win_raw;
    logic [sws_pkg::SIZE_CFG_W-1:0]  size_raw;
    logic                            adv1, adv2, adv3;
    logic                            take_in, mv12, mv23;
    logic [sws_pkg::SIZE_W-1:0]      col_ext, row_ext, win_ext;
    logic                            col_last, row_last;
    logic [sws_pkg::WIN_IDX_W-1:0]   win_lo, row_old_lo;

    logic signed [sws_pkg::HSUM_W-1:0]   h_base, h_old, h_val;
    logic signed [sws_pkg::CSUM_W-1:0]   c_base, c_old, c_val;
    logic [sws_pkg::CSUM_W-1:0]          csum_rd;
    logic [sws_pkg::HSUM_W-1:0]          hsum_rd;

    // handshake chain
    always_comb
    begin
        adv3         = !v3_reg || sums.ready;
        adv2         = !v2_reg || adv3;
        adv1         = !v1_reg || adv2;
        take_in      = pixels.valid && adv1;
        mv12         = v1_reg && adv2;
        mv23         = v2_reg && adv3;
        pixels.ready = adv1;
    end

    // configuration and raster position
    always_comb
    begin
        win_raw   = cfg_data[sws_pkg::WIN_CFG_W-1:0];
        size_raw  = cfg_data[sws_pkg::SIZE_CFG_W-1:0];
        win_next  = win_reg;
        size_next = size_reg;
        col_ext   = sws_pkg::SIZE_W'(col_reg);
        row_ext   = sws_pkg::SIZE_W'(row_reg);
        col_last  = (col_ext + sws_pkg::SIZE_W'(1)) == size_reg;
        row_last  = (row_ext + sws_pkg::SIZE_W'(1)) == size_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        if (take_in)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + sws_pkg::POS_W'(1);
            end
            else
            begin
                col_next = col_reg + sws_pkg::POS_W'(1);
            end
        end
        if (cfg_we && (cfg_index == sws_pkg::REG_WINDOW_SIZE
                       || cfg_index == sws_pkg::REG_IMAGE_SIZE))
        begin
            row_next = '0;
            col_next = '0;
            if (cfg_index == sws_pkg::REG_WINDOW_SIZE)
            begin
                if (win_raw == '0)
                    win_next = sws_pkg::WIN_W'(1);
                else if (int'(win_raw) > sws_pkg::MAX_WIN)
                    win_next = sws_pkg::WIN_W'(sws_pkg::MAX_WIN);
                else
                    win_next = sws_pkg::WIN_W'(win_raw);
            end
            else
            begin
                if (size_raw == '0)
                    size_next = sws_pkg::SIZE_W'(1);
                else if (int'(size_raw) > sws_pkg::MAX_SIZE)
                    size_next = sws_pkg::SIZE_W'(sws_pkg::MAX_SIZE);
                else
                    size_next = sws_pkg::SIZE_W'(size_raw);
            end
        end
    end

    // stage 1 load: position flags and addresses
    always_comb
    begin
        win_ext    = sws_pkg::SIZE_W'(win_reg);
        win_lo     = win_reg[sws_pkg::WIN_IDX_W-1:0];
        row_old_lo = row_reg[sws_pkg::WIN_IDX_W-1:0] - win_lo;

        s1_next           = s1_reg;
        s1_next.sample    = pixels.sample;
        s1_next.col       = col_reg;
        s1_next.first_col = col_reg == '0;
        s1_next.sub_col   = col_ext >= win_ext;
        s1_next.has_hsum  = (col_ext + sws_pkg::SIZE_W'(1)) >= win_ext;
        s1_next.first_row = row_reg == '0;
        s1_next.sub_row   = row_ext >= win_ext;
        s1_next.emit      = (row_ext + sws_pkg::SIZE_W'(1)) >= win_ext;
        s1_next.last      = col_last && row_last;
        s1_next.rw_old    = col_reg[sws_pkg::WIN_IDX_W-1:0] - win_lo;
        s1_next.slot_old  = {row_old_lo, col_reg};
        s1_next.slot_new  = {row_reg[sws_pkg::WIN_IDX_W-1:0], col_reg};
        s1_next.out_row   = row_reg + sws_pkg::POS_W'(1) - sws_pkg::POS_W'(win_reg);
        s1_next.out_col   = col_reg + sws_pkg::POS_W'(1) - sws_pkg::POS_W'(win_reg);
    end

    // stage 1: horizontal running sum
    always_comb
    begin
        h_base = s1_reg.first_col ? '0 : run_reg;
        h_old  = s1_reg.sub_col
               ? sws_pkg::HSUM_W'($signed(row_window_reg[s1_reg.rw_old])) : '0;
        h_val  = h_base + sws_pkg::HSUM_W'($signed(s1_reg.sample)) - h_old;

        run_next = mv12 ? h_val : run_reg;

        s2_next           = s2_reg;
        s2_next.hsum      = h_val;
        s2_next.col       = s1_reg.col;
        s2_next.first_row = s1_reg.first_row;
        s2_next.sub_row   = s1_reg.sub_row;
        s2_next.has_hsum  = s1_reg.has_hsum;
        s2_next.emit      = s1_reg.emit;
        s2_next.last      = s1_reg.last;
        s2_next.slot_new  = s1_reg.slot_new;
        s2_next.out_row   = s1_reg.out_row;
        s2_next.out_col   = s1_reg.out_col;
    end

    // stage 2: column running sum
    always_comb
    begin
        c_base = s2_reg.first_row ? '0 : $signed(csum_rd);
        c_old  = s2_reg.sub_row ? sws_pkg::CSUM_W'($signed(hsum_rd)) : '0;
        c_val  = c_base + sws_pkg::CSUM_W'($signed(s2_reg.hsum)) - c_old;

        s3_next         = s3_reg;
        s3_next.wsum    = c_val[sws_pkg::WSUM_W-1:0];
        s3_next.out_row = s2_reg.out_row;
        s3_next.out_col = s2_reg.out_col;
        s3_next.last    = s2_reg.last;
    end

    always_comb
    begin
        v1_next = adv1 ? pixels.valid : v1_reg;
        v2_next = adv2 ? v1_reg : v2_reg;
        v3_next = adv3 ? (v2_reg && s2_reg.has_hsum && s2_reg.emit) : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= sws_pkg::WIN_W'(1);
            size_reg <= sws_pkg::SIZE_W'(sws_pkg::MAX_SIZE);
            row_reg  <= '0;
            col_reg  <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
        end
        else
        begin
            win_reg  <= win_next;
            size_reg <= size_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            v1_reg   <= v1_next;
            v2_reg   <= v2_next;
            v3_reg   <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_reg <= s1_next;
        end
        if (mv12)
        begin
            s2_reg <= s2_next;
            row_window_reg[s1_reg.col[sws_pkg::WIN_IDX_W-1:0]] <= s1_reg.sample;
        end
        if (mv23)
        begin
            s3_reg <= s3_next;
        end
        run_reg <= run_next;
    end

    sws_ram #(
        .WIDTH (sws_pkg::CSUM_W),
        .DEPTH (sws_pkg::MAX_SIZE)
    ) u_column_sums (
        .clk   (clk),
        .we    (mv23 && s2_reg.has_hsum),
        .waddr (s2_reg.col),
        .wdata (c_val),
        .re    (mv12),
        .raddr (s1_reg.col),
        .rdata (csum_rd)
    );

    sws_ram #(
        .WIDTH (sws_pkg::HSUM_W),
        .DEPTH (sws_pkg::HDEPTH)
    ) u_hsum_lines (
        .clk   (clk),
        .we    (mv23 && s2_reg.has_hsum),
        .waddr (s2_reg.slot_new),
        .wdata (s2_reg.hsum),
        .re    (mv12),
        .raddr (s1_reg.slot_old),
        .rdata (hsum_rd)
    );

    assign sums.valid       = v3_reg;
    assign sums.window_sum  = s3_reg.wsum;
    assign sums.out_row     = s3_reg.out_row;
    assign sums.out_col     = s3_reg.out_col;
    assign sums.last_window = s3_reg.last;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for square_window_sum: predicts every m by m box sum of the
// streamed image and checks the output stream field by field.
// Depends on sws_pkg, sws_pixel_if, sws_sum_if and the RTL.

module testbench;

    import sws_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct {
        logic signed [WSUM_W-1:0] total;
        logic [POS_W-1:0]         top;
        logic [POS_W-1:0]         left;
        logic                     is_last;
    } box_sum_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    sws_pixel_if pixels();
    sws_sum_if   sums();

    square_window_sum u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pixels),
        .sums      (sums)
    );

    // predictor state
    logic [WIN_CFG_W-1:0]   win_setting;
    logic [SIZE_CFG_W-1:0]  size_setting;
    int                     row_hist [MAX_WIN];
    int                     row_acc;
    int                     line_hsum [HDEPTH];
    int                     col_acc [MAX_SIZE];
    int                     next_row;
    int                     next_col;

    box_sum_t               pending_sums [$];
    box_sum_t               oldest;
    int                     fail_count = 0;
    int                     cycle_count = 0;
    int                     send_idle_pct;
    int                     recv_stall_pct;
    int                     phase_num;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        sums.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && sums.valid && sums.ready)
        begin
            if (pending_sums.size() == 0)
            begin
                $error("unexpected transfer: window_sum %0d row %0d col %0d",
                       sums.window_sum, sums.out_row, sums.out_col);
                fail_count++;
            end
            else
            begin
                oldest = pending_sums.pop_front();
                if (sums.window_sum !== oldest.total)
                begin
                    $error("window_sum: expected %0d, got %0d", oldest.total, sums.window_sum);
                    fail_count++;
                end
                if (sums.out_row !== oldest.top)
                begin
                    $error("out_row: expected %0d, got %0d", oldest.top, sums.out_row);
                    fail_count++;
                end
                if (sums.out_col !== oldest.left)
                begin
                    $error("out_col: expected %0d, got %0d", oldest.left, sums.out_col);
                    fail_count++;
                end
                if (sums.last_window !== oldest.is_last)
                begin
                    $error("last_window: expected %0d, got %0d", oldest.is_last,
                           sums.last_window);
                    fail_count++;
                end
            end
        end
    end

    function automatic void update_box_sums(input logic signed [SAMPLE_W-1:0] s);
        int m;
        int n;
        int r;
        int c;
        int x;
        box_sum_t res;
        m = (win_setting == 0) ? 1 : (win_setting > MAX_WIN) ? MAX_WIN : int'(win_setting);
        n = (size_setting == 0) ? 1 : (size_setting > MAX_SIZE) ? MAX_SIZE : int'(size_setting);
        r = (next_row >= n) ? 0 : next_row;
        c = (next_col >= n) ? 0 : next_col;
        x = int'(s);

        if (c == 0)
            row_acc = x;
        else
            row_acc += x;
        if (c >= m)
            row_acc -= row_hist[(c - m) % MAX_WIN];
        row_hist[c % MAX_WIN] = x;

        if (c + 1 >= m)
        begin
            if (r == 0)
                col_acc[c] = row_acc;
            else
                col_acc[c] += row_acc;
            if (r >= m)
                col_acc[c] -= line_hsum[((r - m) % MAX_WIN) * MAX_SIZE + c];
            line_hsum[(r % MAX_WIN) * MAX_SIZE + c] = row_acc;
            if (r + 1 >= m)
            begin
                res.total   = col_acc[c][WSUM_W-1:0];
                res.top     = POS_W'(r + 1 - m);
                res.left    = POS_W'(c + 1 - m);
                res.is_last = (r == n - 1) && (c == n - 1);
                pending_sums.push_back(res);
            end
        end

        if (c + 1 >= n)
        begin
            next_col = 0;
            next_row = (r + 1 >= n) ? 0 : r + 1;
        end
        else
        begin
            next_col = c + 1;
            next_row = r;
        end
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // entered and left just after a falling edge
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixels.valid <= 1'b0;
            @(negedge clk);
        end
        pixels.valid  <= 1'b1;
        pixels.sample <= s;
        do
            @(posedge clk);
        while (!pixels.ready);
        update_box_sums(s);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        pixels.valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_WINDOW_SIZE)
            win_setting = val[WIN_CFG_W-1:0];
        else if (idx == REG_IMAGE_SIZE)
            size_setting = val[SIZE_CFG_W-1:0];
        next_row = 0;
        next_col = 0;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_traffic(input int mode);
        case (mode % 4)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 66;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 66;
            end
            default:
            begin
                send_idle_pct  = 31;
                recv_stall_pct = 31;
            end
        endcase
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] win,
                             input logic [CFG_DATA_W-1:0] size);
        write_reg(REG_IMAGE_SIZE, size);
        write_reg(REG_WINDOW_SIZE, win);
    endtask

    task automatic test_sample_extremes();
        set_traffic(0);
        configure(1, 3);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'shFFFF);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        send_sample(16'sh0001);
        send_sample(16'sh7FFE);
        send_sample(16'sh8001);
    endtask

    task automatic test_degenerate_sizes();
        // zero window acts as 1
        configure(0, 2);
        repeat (4) send_sample(rand_sample());
        // window wider than image: counters run, nothing comes out
        configure(3, 2);
        repeat (4) send_sample(rand_sample());
        // zero image acts as 1x1
        configure(1, 0);
        repeat (2) send_sample(rand_sample());
    endtask

    task automatic test_restart_mid_image();
        configure(2, 3);
        repeat (3) send_sample(rand_sample());
        write_reg(REG_WINDOW_SIZE, 2);
        repeat (4) send_sample(rand_sample());
    endtask

    task automatic test_sum_extremes();
        set_traffic(3);
        configure(31, 16);
        repeat (256) send_sample(16'sh7FFF);
        repeat (256) send_sample(16'sh8000);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] win,
                             input logic [CFG_DATA_W-1:0] size, input int count);
        configure(win, size);
        set_traffic(phase_num);
        phase_num++;
        repeat (count) send_sample(rand_sample());
    endtask

    task automatic test_random_images();
        run_phase(2, 8, 64);
        run_phase(3, 5, 25);
        run_phase(16, 17, 289);
        run_phase(11'h7E3, 7, 49);
        run_phase(1, 2047, 1040);
        run_phase(0, 0, 10);
        run_phase(7, 3, 18);
        run_phase(4, 4, 32);
        run_phase(5, 9, 81);
        run_phase(1, 1, 10);
        run_phase(8, 12, 144);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        pixels.valid   = 1'b0;
        pixels.sample  = '0;
        phase_num      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        win_setting    = WIN_CFG_W'(1);
        size_setting   = SIZE_CFG_W'(1024);
        row_acc        = 0;
        next_row       = 0;
        next_col       = 0;
        foreach (row_hist[i]) row_hist[i] = 0;
        foreach (col_acc[i]) col_acc[i] = 0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_sample_extremes();
        test_degenerate_sizes();
        test_restart_mid_image();
        test_sum_extremes();
        test_random_images();

        wait_idle();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== square_window_sum.f =====
design/sws_pkg.sv
design/sws_pixel_if.sv
design/sws_sum_if.sv
design/sws_ram.sv
design/square_window_sum.sv
dv/testbench.sv
